[rtl/core/sje_pkg.sv]
`timescale 1ns / 1ps
package sje_pkg;

    localparam logic [7:0] SS2_BYTE = 8'h8E;
    localparam logic [7:0] SS3_BYTE = 8'h8F;

    localparam logic [2:0] ERR_OK    = 3'd0;
    localparam logic [2:0] ERR_NUL   = 3'd1;
    localparam logic [2:0] ERR_LEAD  = 3'd2;
    localparam logic [2:0] ERR_TRAIL = 3'd3;
    localparam logic [2:0] ERR_TRUNC = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] error_code;
        logic       last_of_run;
        logic       string_done;
    } t_out_item;

    // One classified input byte: up to three result bytes that share a code
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] nbytes;
        logic [2:0] error_code;
        logic       string_done;
    } t_job;

endpackage

[rtl/core/sje_front.sv]
`timescale 1ns / 1ps
module sje_front
    import sje_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_job_valid,
    output t_job     o_job
);

    logic [7:0] r_held_lead;
    logic       r_lead_pending;
    logic [7:0] n_held_lead;
    logic       n_lead_pending;

    logic [7:0] b;
    logic       eos;
    logic       is_lead;
    logic       trail_ok;
    logic       odd;
    logic [7:0] ten;
    logic [8:0] ku_wide;
    logic [7:0] ku;
    logic       plane2;

    assign b   = i_item.in_byte;
    assign eos = i_item.end_of_string;
    assign is_lead = (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);

    // Trail decode: ten in 1..94 and odd-ku flag
    always_comb begin
        trail_ok = 1'b1;
        odd      = 1'b1;
        ten      = 8'd0;
        if (b >= 8'h40 && b <= 8'h7E) begin
            ten = b - 8'h3F;
        end else if (b >= 8'h80 && b <= 8'h9E) begin
            ten = b - 8'h40;
        end else if (b >= 8'h9F && b <= 8'hFC) begin
            ten = b - 8'h9E;
            odd = 1'b0;
        end else begin
            trail_ok = 1'b0;
            odd      = 1'b0;
        end
    end

    always_comb begin
        plane2  = 1'b0;
        ku_wide = 9'd0;
        if (r_held_lead <= 8'h9F) begin
            ku_wide = {r_held_lead, 1'b0} - 9'h100 - {8'd0, odd};
        end else if (r_held_lead <= 8'hEF) begin
            ku_wide = {r_held_lead, 1'b0} - 9'h180 - {8'd0, odd};
        end else if (r_held_lead <= 8'hF3) begin
            plane2 = 1'b1;
            case (r_held_lead[1:0])
                2'd0:    ku_wide = odd ? 9'd1  : 9'd8;
                2'd1:    ku_wide = odd ? 9'd3  : 9'd4;
                2'd2:    ku_wide = odd ? 9'd5  : 9'd12;
                default: ku_wide = odd ? 9'd13 : 9'd14;
            endcase
        end else begin
            plane2 = 1'b1;
            if (r_held_lead == 8'hF4 && odd) begin
                ku_wide = 9'd15;
            end else begin
                ku_wide = {r_held_lead, 1'b0} - 9'h19A - {8'd0, odd};
            end
        end
        ku = ku_wide[7:0];
    end

    always_comb begin
        n_held_lead    = r_held_lead;
        n_lead_pending = r_lead_pending;
        o_job_valid    = 1'b0;
        o_job.byte0       = 8'd0;
        o_job.byte1       = 8'd0;
        o_job.byte2       = 8'd0;
        o_job.nbytes      = 2'd1;
        o_job.error_code  = ERR_OK;
        o_job.string_done = eos;
        if (i_accept) begin
            o_job_valid = 1'b1;
            if (r_lead_pending) begin
                n_lead_pending = 1'b0;
                n_held_lead    = 8'd0;
                if (!trail_ok) begin
                    o_job.error_code = ERR_TRAIL;
                end else if (plane2) begin
                    o_job.byte0  = SS3_BYTE;
                    o_job.byte1  = ku + 8'hA0;
                    o_job.byte2  = ten + 8'hA0;
                    o_job.nbytes = 2'd3;
                end else begin
                    o_job.byte0  = ku + 8'hA0;
                    o_job.byte1  = ten + 8'hA0;
                    o_job.nbytes = 2'd2;
                end
            end else if (b == 8'd0) begin
                o_job.error_code = ERR_NUL;
            end else if (b < 8'h80) begin
                o_job.byte0 = b;
            end else if (b >= 8'hA1 && b <= 8'hDF) begin
                o_job.byte0  = SS2_BYTE;
                o_job.byte1  = b;
                o_job.nbytes = 2'd2;
            end else if (is_lead) begin
                if (eos) begin
                    o_job.error_code = ERR_TRUNC;
                end else begin
                    // hold the lead, no result yet
                    o_job_valid    = 1'b0;
                    n_held_lead    = b;
                    n_lead_pending = 1'b1;
                end
            end else begin
                o_job.error_code = ERR_LEAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_lead    <= 8'd0;
            r_lead_pending <= 1'b0;
        end else begin
            r_held_lead    <= n_held_lead;
            r_lead_pending <= n_lead_pending;
        end
    end

endmodule

[rtl/core/sje_queue.sv]
`timescale 1ns / 1ps
module sje_queue
    import sje_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wr_job,
    input  logic i_rd,
    output t_job o_rd_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full   = (r_count == FULL_CNT);
    assign o_empty  = (r_count == '0);
    assign wr_en    = i_wr && !o_full;
    assign rd_en    = i_rd && !o_empty;
    assign o_rd_job = r_slots[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slots[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

[rtl/core/sje_back.sv]
`timescale 1ns / 1ps
module sje_back
    import sje_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_job_empty,
    input  logic      i_pop,
    output logic      o_job_done,
    output t_out_item o_item
);

    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       last;

    assign last = (r_idx == (i_job.nbytes - 2'd1));

    always_comb begin
        case (r_idx)
            2'd0:    o_item.out_byte = i_job.byte0;
            2'd1:    o_item.out_byte = i_job.byte1;
            default: o_item.out_byte = i_job.byte2;
        endcase
        o_item.error_code  = i_job.error_code;
        o_item.last_of_run = last;
        o_item.string_done = i_job.string_done;
    end

    // retire the job on its final byte, otherwise advance to the next byte
    assign o_job_done = i_pop && !i_job_empty && last;

    always_comb begin
        n_idx = r_idx;
        if (i_pop && !i_job_empty) begin
            n_idx = last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

[rtl/core/sjis2004_to_eucjis2004_converter.sv]
`timescale 1ns / 1ps
// Each result is registered in the job queue, behind any jobs that are still waiting.
// Throughput: one input byte per cycle while the job queue has room; results leave
// at one per cycle while pop is asserted, so a double-byte character costs two or
// three output bytes in the back-end serializer, which sets the sustained rate.
// Reset: synchronous, active low; clears the held lead and empties the job queue.
module sjis2004_to_eucjis2004_converter
    import sje_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    logic accept;
    logic job_valid;
    t_job front_job;
    t_job head_job;
    logic job_done;

    // A transaction on the input side completes when push meets a non-full queue.
    // Bytes that only hold a lead take a queue-full check too; keeps the front simple.
    assign accept = push && !full;

    // Front: classify the byte, track the pending lead, build a job descriptor
    sje_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .o_job_valid(job_valid),
        .o_job      (front_job)
    );

    // Short queue of jobs decouples front and back stalls
    sje_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_valid),
        .i_wr_job(front_job),
        .i_rd    (job_done),
        .o_rd_job(head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    // Back: serialize each job into one result transaction per output byte
    sje_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (head_job),
        .i_job_empty(empty),
        .i_pop      (pop),
        .o_job_done (job_done),
        .o_item     (o_out_item)
    );

endmodule
